FILE: sv/crtu_pkg.sv
// Package with the record and result types and the calendar tables of the converter.
`default_nettype none
package crtu_pkg;

	typedef struct packed {
		logic [7:0]  record_length;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [7:0]  fraction;
	} rec_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] unix_seconds;
		logic [19:0] microseconds;
	} stamp_t;

	typedef struct packed {
		logic       ok;
		logic       leap;
		logic [7:0] year_ofs;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] fraction;
	} dec_t;

	localparam logic [7:0]  RecordBytes = 8'd10;
	localparam logic [15:0] YearFirst   = 16'd1970;
	localparam logic [15:0] YearLast    = 16'd2100;
	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam logic [16:0] SecsPerMin  = 17'd60;
	localparam logic [31:0] DaySecs     = 32'd86400;
	localparam logic [21:0] UsecPerQtr  = 22'd15625;

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		unique case (m)
			4'd2:                      r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        r = 5'd31;
			default:                   r = 5'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/calendar_record_to_unix_time.sv
// Top level of the calendar record to Unix time converter with its three-stage pipeline.
`default_nettype none
// Converts one current-time record per cycle, unless stalled, into a valid flag, Unix
// seconds and microseconds; rejected records give a zero result. Each transfer passes
// three register stages (check and decode, day count with time of day and fraction
// scaling, then the multiply by the seconds of a day). Every stage holds its own valid
// bit and moves on as soon as the stage after it is free, so the block keeps taking
// records while a result waits at the output until all three stages hold a transfer.
module calendar_record_to_unix_time (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire crtu_pkg::rec_t  rec,
	input  wire logic            rec_valid,
	output logic                 rec_stall,
	output crtu_pkg::stamp_t     stamp,
	output logic                 stamp_valid,
	input  wire logic            stamp_stall
);

	crtu_pkg::dec_t dec;
	crtu_pkg::dec_t dec_s1;
	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic           rdy1;
	logic           rdy2;
	logic           rdy3;

	logic           ok_s2;
	logic [15:0]    days_s2;
	logic [16:0]    tod_s2;
	logic [19:0]    usec_s2;

	logic [15:0]    days_d;
	logic [16:0]    tod_d;
	logic [21:0]    frac_prod;
	logic [31:0]    secs_d;

	crtu_pkg::stamp_t stamp_s3;

	crtu_decode u_decode (
		.rec (rec),
		.dec (dec)
	);

	assign rdy3      = !v_s3 || !stamp_stall;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign rec_stall = !rdy1;

	always_comb begin
		days_d = 16'(dec_s1.year_ofs) * 16'd365
			+ 16'((9'(dec_s1.year_ofs) + 9'd1) >> 2)
			+ 16'(crtu_pkg::month_start(dec_s1.month))
			+ 16'((dec_s1.month > 4'd2) && dec_s1.leap)
			+ 16'(dec_s1.day) - 16'd1;
		tod_d = 17'(dec_s1.hour) * crtu_pkg::SecsPerHour
			+ 17'(dec_s1.minute) * crtu_pkg::SecsPerMin
			+ 17'(dec_s1.second);
		frac_prod = 22'(dec_s1.fraction) * crtu_pkg::UsecPerQtr;
		secs_d = 32'(days_s2) * crtu_pkg::DaySecs + 32'(tod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= rec_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && rec_valid) begin
			dec_s1 <= dec;
		end
		if (rdy2 && v_s1) begin
			ok_s2   <= dec_s1.ok;
			days_s2 <= days_d;
			tod_s2  <= tod_d;
			usec_s2 <= frac_prod[21:2];
		end
		if (rdy3 && v_s2) begin
			stamp_s3.valid_res    <= ok_s2;
			stamp_s3.unix_seconds <= ok_s2 ? secs_d : 32'd0;
			stamp_s3.microseconds <= ok_s2 ? usec_s2 : 20'd0;
		end
	end

	assign stamp       = stamp_s3;
	assign stamp_valid = v_s3;

endmodule
`default_nettype wire

FILE: sv/crtu_decode.sv
// Record checker that validates the fields and reduces them to narrow calendar values.
`default_nettype none
module crtu_decode (
	input  wire crtu_pkg::rec_t rec,
	output crtu_pkg::dec_t      dec
);

	logic        year_ok;
	logic        month_ok;
	logic        time_ok;
	logic        day_ok;
	logic        leap;
	logic [15:0] year_diff;
	logic [4:0]  dim;

	always_comb begin
		year_ok   = (rec.year >= crtu_pkg::YearFirst) && (rec.year <= crtu_pkg::YearLast);
		month_ok  = (rec.month >= 8'd1) && (rec.month <= 8'd12);
		time_ok   = (rec.hour <= 8'd23) && (rec.minute <= 8'd59) && (rec.second <= 8'd59);
		year_diff = rec.year - crtu_pkg::YearFirst;
		// Within the accepted years the only century is 2000, a leap year, and 2100, which is not.
		leap      = (rec.year[1:0] == 2'b00) && (rec.year != crtu_pkg::YearLast);
		dim       = month_ok ? crtu_pkg::month_len(rec.month[3:0]) : 5'd0;
		if (month_ok && (rec.month[3:0] == 4'd2) && leap) begin
			dim = 5'd29;
		end
		day_ok    = (rec.day >= 8'd1) && (rec.day <= {3'b000, dim}) && (dim != 5'd0);

		dec.ok       = (rec.record_length == crtu_pkg::RecordBytes) && year_ok && time_ok
			&& month_ok && day_ok;
		dec.leap     = leap;
		dec.year_ofs = year_diff[7:0];
		dec.month    = rec.month[3:0];
		dec.day      = rec.day[4:0];
		dec.hour     = rec.hour[4:0];
		dec.minute   = rec.minute[5:0];
		dec.second   = rec.second[5:0];
		dec.fraction = rec.fraction;
	end

endmodule
`default_nettype wire

FILE: tb/calendar_record_to_unix_time_tb.sv
// Testbench for the calendar record to Unix time converter: checks every stamp against a predicted one.
`timescale 1ns / 100ps
module calendar_record_to_unix_time_tb;

	class stamp_scoreboard;
		crtu_pkg::stamp_t pending_stamps[$];
		int errors = 0;
		int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		int unsigned days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

		function bit greg_leap(int unsigned y);
			if (y % 400 == 0) return 1'b1;
			if (y % 100 == 0) return 1'b0;
			return (y % 4 == 0);
		endfunction

		function int unsigned leaps_up_to(int unsigned n);
			return n / 4 - n / 100 + n / 400;
		endfunction

		function crtu_pkg::stamp_t to_unix_stamp(crtu_pkg::rec_t r);
			crtu_pkg::stamp_t s;
			int unsigned y, mo, d, dim, days, secs;
			bit ok;
			s = '0;
			y = 32'(r.year);
			mo = 32'(r.month);
			d = 32'(r.day);
			ok = (r.record_length == crtu_pkg::RecordBytes)
				&& y >= 32'(crtu_pkg::YearFirst) && y <= 32'(crtu_pkg::YearLast)
				&& r.hour <= 8'd23 && r.minute <= 8'd59 && r.second <= 8'd59;
			dim = 0;
			if (mo >= 1 && mo <= 12) begin
				dim = month_days[mo - 1];
				if (mo == 2 && greg_leap(y)) dim = 29;
			end
			if (dim == 0 || d < 1 || d > dim) ok = 1'b0;
			if (!ok) return s;
			days = 365 * (y - 32'(crtu_pkg::YearFirst)) + leaps_up_to(y - 1)
				- leaps_up_to(32'(crtu_pkg::YearFirst) - 1) + days_before[mo - 1] + d - 1;
			if (mo > 2 && greg_leap(y)) days = days + 1;
			secs = days * 86400 + 32'(r.hour) * 3600 + 32'(r.minute) * 60 + 32'(r.second);
			s.valid_res = 1'b1;
			s.unix_seconds = secs;
			s.microseconds = 20'((32'(r.fraction) * 1000000) / 256);
			return s;
		endfunction

		function void note_record(crtu_pkg::rec_t r);
			pending_stamps.push_back(to_unix_stamp(r));
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_stamp(crtu_pkg::stamp_t got);
			crtu_pkg::stamp_t want;
			if (pending_stamps.size() == 0) begin
				$display("%0t: unexpected stamp, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_stamps.pop_front();
			if (got.valid_res !== want.valid_res)
				report("valid_res", 32'(want.valid_res), 32'(got.valid_res));
			if (got.unix_seconds !== want.unix_seconds)
				report("unix_seconds", want.unix_seconds, got.unix_seconds);
			if (got.microseconds !== want.microseconds)
				report("microseconds", 32'(want.microseconds), 32'(got.microseconds));
		endfunction

		function int pending();
			return pending_stamps.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	crtu_pkg::rec_t rec;
	logic rec_valid;
	logic rec_stall;
	crtu_pkg::stamp_t stamp;
	logic stamp_valid;
	logic stamp_stall;

	stamp_scoreboard sb;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	calendar_record_to_unix_time uut (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.stamp(stamp),
		.stamp_valid(stamp_valid),
		.stamp_stall(stamp_stall)
	);

	always #5 clk = ~clk;

	function automatic crtu_pkg::rec_t make_record(int len, int y, int mo, int d, int h, int mi,
			int s, int f);
		crtu_pkg::rec_t r;
		r.record_length = 8'(len);
		r.year = 16'(y);
		r.month = 8'(mo);
		r.day = 8'(d);
		r.hour = 8'(h);
		r.minute = 8'(mi);
		r.second = 8'(s);
		r.fraction = 8'(f);
		return r;
	endfunction

	function automatic crtu_pkg::rec_t random_record();
		crtu_pkg::rec_t r;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			r = 72'({$urandom(), $urandom(), $urandom()});
			return r;
		end
		r = make_record(10, $urandom_range(1970, 2100), $urandom_range(1, 12),
			$urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
			$urandom_range(0, 59), $urandom_range(0, 255));
		if (kind >= 7) begin
			case ($urandom_range(0, 6))
				0: r.record_length = 8'($urandom());
				1: r.year = 16'($urandom());
				2: r.month = 8'($urandom());
				3: r.day = 8'($urandom());
				4: r.hour = 8'($urandom_range(20, 255));
				5: r.minute = 8'($urandom_range(55, 255));
				default: r.second = 8'($urandom_range(55, 255));
			endcase
		end
		return r;
	endfunction

	function automatic int idle_gap();
		if (quiet || $urandom_range(0, 3) != 0) return 0;
		return $urandom_range(1, 14);
	endfunction

	task automatic send_record(crtu_pkg::rec_t r, int gap);
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec <= r;
		rec_valid <= 1'b1;
		do @(posedge clk); while (rec_stall !== 1'b0);
		sb.note_record(r);
	endtask

	task automatic wait_for_stamps();
		rec_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int burst;
		burst = 0;
		stamp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stamp_valid === 1'b1 && stamp_stall === 1'b0) sb.check_stamp(stamp);
			if (hold_request) begin
				burst = 200;
				hold_request = 1'b0;
			end else if (burst == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 14);
			end
			if (burst > 0) begin
				stamp_stall <= 1'b1;
				burst--;
			end else begin
				stamp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int n;
		sb = new();
		arst_n = 1'b0;
		rec_valid = 1'b0;
		rec = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_record(make_record(10, 1970, 1, 1, 0, 0, 0, 0), idle_gap());
		send_record(make_record(10, 2100, 12, 31, 23, 59, 59, 255), idle_gap());
		send_record(make_record(9, 2000, 6, 15, 12, 30, 30, 128), idle_gap());
		send_record(make_record(11, 2000, 6, 15, 12, 30, 30, 128), idle_gap());
		send_record(make_record(0, 2000, 6, 15, 12, 30, 30, 1), idle_gap());
		send_record(make_record(255, 2000, 6, 15, 12, 30, 30, 1), idle_gap());
		send_record(make_record(10, 1969, 12, 31, 23, 59, 59, 0), idle_gap());
		send_record(make_record(10, 2101, 1, 1, 0, 0, 0, 0), idle_gap());
		send_record(make_record(10, 0, 1, 1, 0, 0, 0, 0), idle_gap());
		send_record(make_record(10, 65535, 1, 1, 0, 0, 0, 0), idle_gap());
		send_record(make_record(10, 2010, 5, 5, 24, 0, 0, 10), idle_gap());
		send_record(make_record(10, 2010, 5, 5, 0, 60, 0, 10), idle_gap());
		send_record(make_record(10, 2010, 5, 5, 0, 0, 60, 10), idle_gap());
		send_record(make_record(10, 2010, 5, 5, 255, 255, 255, 10), idle_gap());
		send_record(make_record(10, 2010, 0, 5, 1, 1, 1, 10), idle_gap());
		send_record(make_record(10, 2010, 13, 5, 1, 1, 1, 10), idle_gap());
		send_record(make_record(10, 2010, 255, 5, 1, 1, 1, 10), idle_gap());
		send_record(make_record(10, 2010, 5, 0, 1, 1, 1, 10), idle_gap());
		send_record(make_record(10, 2010, 5, 255, 1, 1, 1, 10), idle_gap());
		send_record(make_record(10, 2000, 2, 29, 6, 7, 8, 64), idle_gap());
		send_record(make_record(10, 2100, 2, 29, 6, 7, 8, 64), idle_gap());
		send_record(make_record(10, 2024, 2, 29, 23, 59, 59, 200), idle_gap());
		send_record(make_record(10, 2023, 2, 29, 0, 0, 0, 200), idle_gap());
		send_record(make_record(10, 2024, 3, 1, 0, 0, 0, 3), idle_gap());
		send_record(make_record(10, 2023, 4, 31, 0, 0, 0, 3), idle_gap());
		send_record(make_record(10, 2099, 12, 31, 23, 59, 59, 127), idle_gap());
		wait_for_stamps();

		for (n = 0; n < 600; n++) begin
			quiet = (n >= 500);
			if (n == 150) hold_request = 1'b1;
			if (n == 190 || n == 420) wait_for_stamps();
			if (n >= 150 && n < 190) send_record(random_record(), 0);
			else send_record(random_record(), idle_gap());
		end

		wait_for_stamps();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

FILE: calendar_record_to_unix_time.f
sv/crtu_pkg.sv
sv/crtu_decode.sv
sv/calendar_record_to_unix_time.sv
tb/calendar_record_to_unix_time_tb.sv
